[hdl/byte_plane_shuffle_macros.svh]
// ----------------------------------------------------------------------------
// byte_plane_shuffle assertion macros
// Shared assertion wrappers. Defining ASSERT_OFF compiles them away.
// ----------------------------------------------------------------------------
`ifndef BYTE_PLANE_SHUFFLE_MACROS_SVH
`define BYTE_PLANE_SHUFFLE_MACROS_SVH

`ifndef ASSERT_OFF
// The consequent must hold in the same cycle as the antecedent.
`define BPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("byte_plane_shuffle check failed");
// The consequent must hold in the cycle after the antecedent.
`define BPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("byte_plane_shuffle check failed");
`else
`define BPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[hdl/bps_pkg.sv]
// ----------------------------------------------------------------------------
// bps_pkg
// Types and constants shared by the byte plane shuffle modules.
// ----------------------------------------------------------------------------
package bps_pkg;

    localparam int MAX_BLOCK_BYTES = 4096;
    localparam int ADDR_W          = $clog2(MAX_BLOCK_BYTES);
    localparam int POS_W           = 13;
    localparam int TS_W            = 8;
    localparam int CFG_W           = 13;
    localparam int CFG_IDX_W       = 2;

    // Restoring divider: one quotient bit per cycle.
    localparam int DIV_STEPS = POS_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [TS_W-1:0]  TYPE_SIZE_RST   = TS_W'(4);
    localparam logic [POS_W-1:0] BLOCK_BYTES_RST = POS_W'(MAX_BLOCK_BYTES);
    localparam logic             DIRECTION_RST   = 1'b0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TYPE_SIZE   = 2'd0,
        CFG_BLOCK_BYTES = 2'd1,
        CFG_DIRECTION   = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_READ  = 1'b1
    } t_cmd;

    typedef enum logic {
        DIR_SHUFFLE   = 1'b0,
        DIR_UNSHUFFLE = 1'b1
    } t_dir;

    typedef struct packed {
        logic       cmd;
        logic [7:0] in_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       block_end;
    } t_out_item;

    // Controls for the source address walker.
    typedef struct packed {
        logic clear;
        logic step;
        logic dir;
    } t_walk_ctl;

endpackage

[hdl/byte_plane_shuffle.sv]
// ----------------------------------------------------------------------------
// byte_plane_shuffle
// Byte transpose filter: stores one block, then reads it back in plane order (shuffle) or element order (unshuffle).
// ----------------------------------------------------------------------------
// A write item is taken while idle; a read item goes first through the registered read
// port of the 4096 byte store and then into the output register, which may
// still hold an earlier result while the next item is taken. After reset and
// after every register write the block is not ready while the divider
// works out the element count and tail length, one quotient bit
// per cycle. Store entries are undefined until written and are never cleared.
`include "byte_plane_shuffle_macros.svh"

module byte_plane_shuffle (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  bps_pkg::t_in_item             i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output bps_pkg::t_out_item            o_out_data,
    input  logic                          i_cfg_we,
    input  logic [bps_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bps_pkg::CFG_W-1:0]     i_cfg_data
);
    import bps_pkg::*;

    typedef enum logic [1:0] {
        S_START,
        S_DIV,
        S_IDLE,
        S_HOLD
    } t_state;

    t_state           r_state;
    logic [TS_W-1:0]  r_ts;
    logic [POS_W-1:0] r_blk;
    logic             r_dir;
    logic [POS_W-1:0] r_count;
    logic [POS_W-1:0] r_body;
    logic [POS_W-1:0] r_wr_pos;
    logic [POS_W-1:0] r_rd_pos;
    logic             r_rd_last;
    logic [7:0]       r_rd_data;
    logic             r_out_valid;
    t_out_item        r_out;

    logic [7:0]       r_mem [MAX_BLOCK_BYTES];

    logic [TS_W-1:0]  w_ts;
    logic [POS_W-1:0] w_blk;
    logic             w_cfg_hit;
    logic             w_acc;
    logic             w_acc_wr;
    logic             w_acc_rd;
    logic             w_in_body;
    logic             w_last;
    logic             w_store;
    logic [POS_W-1:0] w_src;
    logic [ADDR_W-1:0] w_rd_addr;
    logic             w_div_done;
    logic [POS_W-1:0] w_quot;
    logic [TS_W-1:0]  w_rem;
    t_walk_ctl        w_walk;

    always_comb begin
        w_ts  = (r_ts == '0) ? TS_W'(1) : r_ts;
        if (r_blk == '0) begin
            w_blk = POS_W'(1);
        end else if (r_blk > POS_W'(MAX_BLOCK_BYTES)) begin
            w_blk = POS_W'(MAX_BLOCK_BYTES);
        end else begin
            w_blk = r_blk;
        end
        w_cfg_hit  = i_cfg_we && (i_cfg_idx == CFG_TYPE_SIZE || i_cfg_idx == CFG_BLOCK_BYTES
                     || i_cfg_idx == CFG_DIRECTION);
        w_acc      = i_in_valid && o_in_ready;
        w_acc_wr   = w_acc && (i_in_data.cmd == CMD_WRITE);
        w_acc_rd   = w_acc && (i_in_data.cmd == CMD_READ);
        w_store    = w_acc_wr && (r_wr_pos < w_blk);
        w_in_body  = (r_rd_pos < r_body);
        w_last     = (({1'b0, r_rd_pos} + 1'b1) >= {1'b0, w_blk});
        // Bytes past the last whole element come straight from their own position.
        w_rd_addr  = w_in_body ? w_src[ADDR_W-1:0] : r_rd_pos[ADDR_W-1:0];
        w_walk.clear = w_cfg_hit || !i_rst_n || (w_acc_rd && w_last);
        w_walk.step  = w_acc_rd && w_in_body;
        w_walk.dir   = r_dir;
    end

    assign o_in_ready = (r_state == S_IDLE);

    bps_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_START),
        .i_dividend (w_blk),
        .i_divisor  (w_ts),
        .o_done     (w_div_done),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    bps_addr u_addr (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_walk),
        .i_type_size  (w_ts),
        .i_elem_count (r_count),
        .o_src        (w_src)
    );

    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_mem[r_wr_pos[ADDR_W-1:0]] <= i_in_data.in_byte;
        end
        if (w_acc_rd) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_START;
            r_ts        <= TYPE_SIZE_RST;
            r_blk       <= BLOCK_BYTES_RST;
            r_dir       <= DIRECTION_RST;
            r_count     <= '0;
            r_body      <= '0;
            r_wr_pos    <= '0;
            r_rd_pos    <= '0;
            r_rd_last   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // In the hold state the output register reloads as the old result leaves.
            if (o_out_valid && i_out_ready && (w_cfg_hit || r_state != S_HOLD)) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_TYPE_SIZE:   r_ts  <= i_cfg_data[TS_W-1:0];
                    CFG_BLOCK_BYTES: r_blk <= i_cfg_data[POS_W-1:0];
                    CFG_DIRECTION:   r_dir <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (w_cfg_hit) begin
                r_wr_pos <= '0;
                r_rd_pos <= '0;
                r_state  <= S_START;
            end else begin
                unique case (r_state)
                    S_START: begin
                        r_state <= S_DIV;
                    end
                    S_DIV: begin
                        if (w_div_done) begin
                            r_count <= w_quot;
                            r_body  <= POS_W'(w_blk - POS_W'(w_rem));
                            r_state <= S_IDLE;
                        end
                    end
                    S_IDLE: begin
                        if (w_store) begin
                            r_wr_pos <= r_wr_pos + 1'b1;
                        end
                        if (w_acc_rd) begin
                            r_rd_last <= w_last;
                            r_state   <= S_HOLD;
                            if (w_last) begin
                                r_rd_pos <= '0;
                                r_wr_pos <= '0;
                            end else begin
                                r_rd_pos <= r_rd_pos + 1'b1;
                            end
                        end
                    end
                    S_HOLD: begin
                        if (!r_out_valid || i_out_ready) begin
                            r_out_valid     <= 1'b1;
                            r_out.out_byte  <= r_rd_data;
                            r_out.block_end <= r_rd_last;
                            r_state         <= S_IDLE;
                        end
                    end
                    default: r_state <= S_START;
                endcase
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `BPS_ASSERT_IMP(a_wr_in_block, i_clk, i_rst_n, r_state == S_IDLE, r_wr_pos <= w_blk)
    `BPS_ASSERT_IMP(a_src_in_body, i_clk, i_rst_n, w_acc_rd && w_in_body, w_src < r_body)
    `BPS_ASSERT_NXT(a_last_restarts, i_clk, i_rst_n, w_acc_rd && w_last && !w_cfg_hit,
                    r_rd_pos == '0 && r_wr_pos == '0)
    `BPS_ASSERT_NXT(a_hold_keeps_out, i_clk, i_rst_n,
                    r_state == S_HOLD && r_out_valid && !i_out_ready && !w_cfg_hit,
                    r_state == S_HOLD && r_out_valid)

endmodule

[hdl/bps_div.sv]
// ----------------------------------------------------------------------------
// bps_div
// Iterative restoring divider giving the element count and tail length.
// ----------------------------------------------------------------------------
module bps_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [bps_pkg::POS_W-1:0]  i_dividend,
    input  logic [bps_pkg::TS_W-1:0]   i_divisor,
    output logic                       o_done,
    output logic [bps_pkg::POS_W-1:0]  o_quot,
    output logic [bps_pkg::TS_W-1:0]   o_rem
);
    import bps_pkg::*;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [TS_W-1:0]      r_rem;
    logic [POS_W-1:0]     r_quot;

    logic [TS_W:0]        w_shift;
    logic                 w_fits;
    logic [TS_W-1:0]      w_rem_n;

    always_comb begin
        w_shift = {r_rem, r_quot[POS_W-1]};
        w_fits  = (w_shift >= {1'b0, i_divisor});
        w_rem_n = w_fits ? TS_W'(w_shift - {1'b0, i_divisor}) : w_shift[TS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_rem  <= '0;
            r_quot <= i_dividend;
        end else if (r_busy) begin
            // The dividend shifts out of the top while quotient bits enter below.
            r_rem  <= w_rem_n;
            r_quot <= {r_quot[POS_W-2:0], w_fits};
            r_cnt  <= r_cnt + 1'b1;
            if (r_cnt == DIV_LAST) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

[hdl/bps_addr.sv]
// ----------------------------------------------------------------------------
// bps_addr
// Plane and element counters that walk the source address of each read.
// ----------------------------------------------------------------------------
module bps_addr (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  bps_pkg::t_walk_ctl         i_ctl,
    input  logic [bps_pkg::TS_W-1:0]   i_type_size,
    input  logic [bps_pkg::POS_W-1:0]  i_elem_count,
    output logic [bps_pkg::POS_W-1:0]  o_src
);
    import bps_pkg::*;

    logic [TS_W-1:0]  r_plane;
    logic [POS_W-1:0] r_elem;
    logic [POS_W-1:0] r_src;

    logic [TS_W-1:0]  n_plane;
    logic [POS_W-1:0] n_elem;
    logic [POS_W-1:0] n_src;
    logic [TS_W:0]    w_plane_inc;
    logic [POS_W:0]   w_elem_inc;

    always_comb begin
        w_plane_inc = {1'b0, r_plane} + 1'b1;
        w_elem_inc  = {1'b0, r_elem} + 1'b1;
        n_plane     = r_plane;
        n_elem      = r_elem;
        n_src       = r_src;
        if (i_ctl.clear) begin
            n_plane = '0;
            n_elem  = '0;
            n_src   = '0;
        end else if (i_ctl.step) begin
            if (i_ctl.dir == DIR_SHUFFLE) begin
                // Walk down one plane, one element stride at a time.
                if (w_elem_inc >= {1'b0, i_elem_count}) begin
                    n_elem  = '0;
                    n_plane = w_plane_inc[TS_W-1:0];
                    n_src   = POS_W'(w_plane_inc);
                end else begin
                    n_elem  = w_elem_inc[POS_W-1:0];
                    n_src   = POS_W'(r_src + POS_W'(i_type_size));
                end
            end else begin
                // Gather one element from every plane in turn.
                if (w_plane_inc >= {1'b0, i_type_size}) begin
                    n_plane = '0;
                    n_elem  = w_elem_inc[POS_W-1:0];
                    n_src   = w_elem_inc[POS_W-1:0];
                end else begin
                    n_plane = w_plane_inc[TS_W-1:0];
                    n_src   = POS_W'(r_src + i_elem_count);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane <= '0;
            r_elem  <= '0;
            r_src   <= '0;
        end else begin
            r_plane <= n_plane;
            r_elem  <= n_elem;
            r_src   <= n_src;
        end
    end

    assign o_src = r_src;

endmodule

[verif/byte_plane_shuffle_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// byte_plane_shuffle_test
// Self-checking bench for the byte plane shuffle. A directed table covers the
// register extremes and corner cases, then random blocks of writes and reads
// run under random idling and stalls, each result checked in order against a
// transpose model kept inside the bench.
// ----------------------------------------------------------------------------
module byte_plane_shuffle_test;
    import bps_pkg::*;

    localparam int unsigned IDLE_PCT   = 37;
    localparam int unsigned RAND_ITEMS = 360;
    localparam int unsigned CALM_ITEMS = 200;
    localparam int unsigned WDOG_LIMIT = 3000;
    localparam int unsigned SETTLE_CYC = 8;
    localparam int unsigned DRAIN_CYC  = 20;

    // Index 3 is outside the register list and must leave the block alone.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_NONE     = 2'd3;
    localparam logic [CFG_W-1:0]     BLOCK_BYTES_OVER = 13'h1FFF;

    typedef enum logic { ROW_ITEM = 1'b0, ROW_CFG = 1'b1 } t_row_kind;

    typedef struct packed {
        t_row_kind            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     data;
        t_cmd                 cmd;
        logic [7:0]           value;
        logic                 golden_on;
        logic [7:0]           g_byte;
        logic                 g_end;
    } t_step_row;

    localparam int unsigned NUM_ROWS = 32;
    localparam t_step_row DIRECTED [NUM_ROWS] = '{
        '{ROW_ITEM, CFG_TYPE_SIZE, 13'd0, CMD_WRITE, 8'hA5, 1'b0, 8'h00, 1'b0},
        '{ROW_ITEM, CFG_TYPE_SIZE, 13'd0, CMD_READ, 8'h00, 1'b1, 8'hA5, 1'b0},
        '{ROW_CFG, CFG_TYPE_SIZE, 13'd0, CMD_WRITE, 8'h00, 1'b0, 8'h00, 1'b0},
        '{ROW_CFG, CFG_BLOCK_BYTES, 13'd0, CMD_WRITE, 8'h00, 1'b0, 8'h00, 1'b0},
        '{ROW_ITEM, CFG_TYPE_SIZE, 13'd0, CMD_WRITE, 8'hFF, 1'b0, 8'h00, 1'b0},
        '{ROW_ITEM, CFG_TYPE_SIZE, 13'd0, CMD_WRITE, 8'h00, 1'b0, 8'h00, 1'b0},
        '{ROW_ITEM, CFG_TYPE_SIZE, 13'd0, CMD_READ, 8'hFF, 1'b1, 8'hFF, 1'b1},
        '{ROW_CFG, CFG_BLOCK_BYTES, 13'd6, CMD_WRITE, 8'h00, 1'b0, 8'h00, 1'b0},
        '{ROW_CFG, CFG_TYPE_SIZE, 13'd2, CMD_WRITE, 8'h00, 1'b0, 8'h00, 1'b0},
        '{ROW_ITEM, CFG_TYPE_SIZE, 13'd0, CMD_WRITE, 8'h01, 1'b0, 8'h00, 1'b0},
        '{ROW_ITEM, CFG_TYPE_SIZE, 13'd0, CMD_WRITE, 8'h80, 1'b0, 8'h00, 1'b0},
        '{ROW_ITEM, CFG_TYPE_SIZE, 13'd0, CMD_WRITE, 8'h7F, 1'b0, 8'h00, 1'b0},
        '{ROW_ITEM, CFG_TYPE_SIZE, 13'd0, CMD_WRITE, 8'hFE, 1'b0, 8'h00, 1'b0},
        '{ROW_ITEM, CFG_TYPE_SIZE, 13'd0, CMD_WRITE, 8'h55, 1'b0, 8'h00, 1'b0},
        '{ROW_ITEM, CFG_TYPE_SIZE, 13'd0, CMD_WRITE, 8'hAA, 1'b0, 8'h00, 1'b0},
        '{ROW_ITEM, CFG_TYPE_SIZE, 13'd0, CMD_READ, 8'h00, 1'b0, 8'h00, 1'b0},
        '{ROW_ITEM, CFG_TYPE_SIZE, 13'd0, CMD_READ, 8'hFF, 1'b0, 8'h00, 1'b0},
        '{ROW_ITEM, CFG_TYPE_SIZE, 13'd0, CMD_READ, 8'h00, 1'b0, 8'h00, 1'b0},
        '{ROW_ITEM, CFG_TYPE_SIZE, 13'd0, CMD_READ, 8'hFF, 1'b0, 8'h00, 1'b0},
        '{ROW_ITEM, CFG_TYPE_SIZE, 13'd0, CMD_READ, 8'h00, 1'b0, 8'h00, 1'b0},
        '{ROW_ITEM, CFG_TYPE_SIZE, 13'd0, CMD_READ, 8'hFF, 1'b0, 8'h00, 1'b0},
        '{ROW_CFG, CFG_DIRECTION, 13'd1, CMD_WRITE, 8'h00, 1'b0, 8'h00, 1'b0},
        '{ROW_ITEM, CFG_TYPE_SIZE, 13'd0, CMD_READ, 8'h00, 1'b0, 8'h00, 1'b0},
        '{ROW_ITEM, CFG_TYPE_SIZE, 13'd0, CMD_READ, 8'h00, 1'b0, 8'h00, 1'b0},
        '{ROW_ITEM, CFG_TYPE_SIZE, 13'd0, CMD_READ, 8'h00, 1'b0, 8'h00, 1'b0},
        '{ROW_ITEM, CFG_TYPE_SIZE, 13'd0, CMD_READ, 8'h00, 1'b0, 8'h00, 1'b0},
        '{ROW_ITEM, CFG_TYPE_SIZE, 13'd0, CMD_READ, 8'h00, 1'b0, 8'h00, 1'b0},
        '{ROW_ITEM, CFG_TYPE_SIZE, 13'd0, CMD_READ, 8'h00, 1'b0, 8'h00, 1'b0},
        '{ROW_CFG, CFG_TYPE_SIZE, 13'd255, CMD_WRITE, 8'h00, 1'b0, 8'h00, 1'b0},
        '{ROW_ITEM, CFG_TYPE_SIZE, 13'd0, CMD_READ, 8'h00, 1'b0, 8'h00, 1'b0},
        '{ROW_CFG, CFG_IDX_NONE, 13'h1FFF, CMD_WRITE, 8'h00, 1'b0, 8'h00, 1'b0},
        '{ROW_ITEM, CFG_TYPE_SIZE, 13'd0, CMD_READ, 8'h00, 1'b0, 8'h00, 1'b0}
    };

    logic             clk      = 1'b0;
    logic             rst_n    = 1'b0;
    logic             in_valid = 1'b0;
    t_in_item         in_data  = '0;
    logic             out_ready = 1'b0;
    logic             cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx  = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic             o_in_ready;
    logic             o_out_valid;
    t_out_item        o_out_data;

    // Model of the block: byte store, walk counters and registers.
    logic [7:0]       store_mem [MAX_BLOCK_BYTES];
    bit               stored    [MAX_BLOCK_BYTES];
    int unsigned      wr_pos, rd_pos, elem_count, plane_idx, elem_idx;
    logic [TS_W-1:0]  ts_reg;
    logic [POS_W-1:0] blk_reg;
    t_dir             dir_reg;

    t_out_item        pending_bytes [$];
    t_out_item        head_exp;
    int unsigned      live_items = 0;
    int unsigned      fails = 0;
    int unsigned      quiet_cycles = 0;
    bit               calm = 1'b0;

    byte_plane_shuffle i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic int unsigned elem_bytes();
        return (ts_reg == 0) ? 1 : int'(ts_reg);
    endfunction

    function automatic int unsigned block_len();
        if (blk_reg == 0) return 1;
        if (blk_reg > MAX_BLOCK_BYTES) return MAX_BLOCK_BYTES;
        return int'(blk_reg);
    endfunction

    function automatic void restart_block();
        wr_pos     = 0;
        rd_pos     = 0;
        plane_idx  = 0;
        elem_idx   = 0;
        elem_count = block_len() / elem_bytes();
    endfunction

    // Source entry of the next read; tail bytes past the last whole element
    // come straight from their own position.
    function automatic int unsigned next_src();
        int unsigned ts;
        int unsigned src;
        ts = elem_bytes();
        if (rd_pos < elem_count * ts) begin
            if (dir_reg == DIR_SHUFFLE) begin
                src = elem_idx * ts + plane_idx;
            end else begin
                src = plane_idx * elem_count + elem_idx;
            end
        end else begin
            src = rd_pos;
        end
        if (src >= MAX_BLOCK_BYTES) src = (rd_pos < MAX_BLOCK_BYTES) ? rd_pos : 0;
        return src;
    endfunction

    function automatic void shuffle_item(input t_in_item item, output bit has_res,
                                         output t_out_item res);
        int unsigned ts;
        int unsigned src;
        ts      = elem_bytes();
        has_res = 1'b0;
        res     = '0;
        if (item.cmd == CMD_WRITE) begin
            if (wr_pos < block_len()) begin
                store_mem[wr_pos] = item.in_byte;
                stored[wr_pos]    = 1'b1;
                wr_pos++;
                live_items++;
            end
            return;
        end
        src = next_src();
        if (rd_pos < elem_count * ts) begin
            if (dir_reg == DIR_SHUFFLE) begin
                elem_idx++;
                if (elem_idx >= elem_count) begin
                    elem_idx = 0;
                    plane_idx++;
                end
            end else begin
                plane_idx++;
                if (plane_idx >= ts) begin
                    plane_idx = 0;
                    elem_idx++;
                end
            end
        end
        res.out_byte  = store_mem[src];
        res.block_end = (rd_pos + 1 >= block_len());
        if (res.block_end) begin
            restart_block();
        end else begin
            rd_pos++;
        end
        has_res = 1'b1;
        live_items++;
    endfunction

    function automatic void layout_write(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_W-1:0] data);
        case (idx)
            CFG_TYPE_SIZE:   ts_reg  = data[TS_W-1:0];
            CFG_BLOCK_BYTES: blk_reg = data;
            CFG_DIRECTION:   dir_reg = t_dir'(data[0]);
            default:         return;
        endcase
        restart_block();
    endfunction

    task automatic send_item(input t_in_item item, input bit golden_on,
                             input t_out_item golden);
        int unsigned gap;
        bit          has_res;
        t_out_item   res;
        gap = 0;
        if (!calm && $urandom_range(0, 99) < IDLE_PCT) gap = $urandom_range(1, 4);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (!o_in_ready);
        shuffle_item(item, has_res, res);
        if (has_res) pending_bytes.push_back(golden_on ? golden : res);
    endtask

    // A register write restarts the block, so it waits until every result has
    // left and the last read has cleared the pipeline.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        in_valid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        layout_write(idx, data);
    endtask

    // Reads only go out when their source entry holds a written byte.
    task automatic send_rand(input bit want_read);
        t_in_item item;
        item.in_byte = 8'($urandom_range(0, 255));
        if (want_read && stored[next_src()]) begin
            item.cmd = CMD_READ;
        end else begin
            item.cmd = CMD_WRITE;
        end
        send_item(item, 1'b0, '0);
    endtask

    task automatic fill_and_drain();
        while (wr_pos < block_len()) send_rand(1'b0);
        do send_rand(1'b1); while (rd_pos != 0);
    endtask

    task automatic choose_layout();
        logic [CFG_W-1:0] blk;
        if ($urandom_range(0, 7) == 0) begin
            blk = CFG_W'($urandom_range(49, 300));
        end else begin
            blk = CFG_W'($urandom_range(1, 48));
        end
        if ($urandom_range(0, 1) != 0) begin
            if ($urandom_range(0, 7) == 0) begin
                cfg_write(CFG_TYPE_SIZE, CFG_W'($urandom_range(0, 255)));
            end else begin
                cfg_write(CFG_TYPE_SIZE, CFG_W'($urandom_range(1, 8)));
            end
        end
        if ($urandom_range(0, 1) != 0) cfg_write(CFG_DIRECTION, CFG_W'($urandom_range(0, 1)));
        cfg_write(CFG_BLOCK_BYTES, blk);
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (pending_bytes.size() == 0) begin
                    $error("unexpected item: out_byte %02h block_end %0b",
                           o_out_data.out_byte, o_out_data.block_end);
                    fails++;
                end else begin
                    head_exp = pending_bytes.pop_front();
                    if (o_out_data.out_byte !== head_exp.out_byte) begin
                        $error("out_byte: expected %02h, actual %02h",
                               head_exp.out_byte, o_out_data.out_byte);
                        fails++;
                    end
                    if (o_out_data.block_end !== head_exp.block_end) begin
                        $error("block_end: expected %0b, actual %0b",
                               head_exp.block_end, o_out_data.block_end);
                        fails++;
                    end
                end
            end
            out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready) || cfg_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WDOG_LIMIT) begin
                $display("byte_plane_shuffle: mismatch");
                $finish;
            end
        end
    end

    initial begin
        t_in_item    item;
        t_out_item   golden;
        int unsigned burst;
        ts_reg  = TYPE_SIZE_RST;
        blk_reg = BLOCK_BYTES_RST;
        dir_reg = t_dir'(DIRECTION_RST);
        restart_block();
        foreach (stored[i]) stored[i] = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED[r]) begin
            if (DIRECTED[r].kind == ROW_CFG) begin
                cfg_write(DIRECTED[r].idx, DIRECTED[r].data);
            end else begin
                item.cmd         = DIRECTED[r].cmd;
                item.in_byte     = DIRECTED[r].value;
                golden.out_byte  = DIRECTED[r].g_byte;
                golden.block_end = DIRECTED[r].g_end;
                send_item(item, DIRECTED[r].golden_on, golden);
            end
        end

        // Mostly whole blocks with random content; the rest is a mix of
        // early reads, writes past the end and restarts in mid block.
        live_items = 0;
        while (live_items < RAND_ITEMS) begin
            choose_layout();
            if ($urandom_range(0, 9) < 7) begin
                repeat ($urandom_range(1, 3)) fill_and_drain();
            end else begin
                burst = $urandom_range(10, 40);
                repeat (burst) begin
                    case ($urandom_range(0, 99))
                        0, 1:    cfg_write(CFG_IDX_NONE, CFG_W'($urandom_range(0, 8191)));
                        2, 3:    choose_layout();
                        default: send_rand($urandom_range(0, 1) != 0);
                    endcase
                end
            end
        end

        // A stretch with no idling on either side. The oversized setting
        // saturates to the store depth, so the widest element sets the
        // element count from the full depth; only the start of that block
        // is walked here.
        cfg_write(CFG_TYPE_SIZE, CFG_W'(255));
        cfg_write(CFG_DIRECTION, CFG_W'($urandom_range(0, 1)));
        cfg_write(CFG_BLOCK_BYTES, BLOCK_BYTES_OVER);
        calm = 1'b1;
        repeat (CALM_ITEMS) send_rand(1'b1);
        calm = 1'b0;

        in_valid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
        if (fails == 0 && pending_bytes.size() == 0) begin
            $display("byte_plane_shuffle: match");
        end else begin
            $display("byte_plane_shuffle: mismatch");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+hdl
hdl/bps_pkg.sv
hdl/bps_div.sv
hdl/bps_addr.sv
hdl/byte_plane_shuffle.sv
verif/byte_plane_shuffle_test.sv
